// ----- design/neighbor_link_weights_assert.svh -----
// Assertion macros shared by the neighbor link weight checkers.
// Depends on a clk and an rst signal in the scope where a macro is used.
`ifndef NEIGHBOR_LINK_WEIGHTS_ASSERT_SVH
`define NEIGHBOR_LINK_WEIGHTS_ASSERT_SVH

// Check outside reset.
`define NLW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check at every edge, reset included.
`define NLW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/nlw_pkg.sv -----
// Types and constants of the neighbor link weight block.
// No dependencies; imported by nlw_front, nlw_lane and neighbor_link_weights.
package nlw_pkg;

  // Pixel as stored in the line buffer: red in the low byte.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Neighbor lies outside the image: force that weight to zero.
  typedef struct packed {
    logic left;
    logic upleft;
    logic up;
    logic upright;
  } border_t;

  typedef enum logic [1:0] {
    CFG_ROW_WIDTH = 2'd0,
    CFG_GAMMA     = 2'd1,
    CFG_BETA      = 2'd2
  } cfg_reg_e;

  localparam int unsigned ROW_WIDTH_W = 12;
  localparam int unsigned GAMMA_W     = 16;
  localparam int unsigned BETA_W      = 32;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned WEIGHT_W    = 24;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 12'd640;
  localparam logic [GAMMA_W-1:0]     GAMMA_RESET     = 16'd12800;
  localparam logic [BETA_W-1:0]      BETA_RESET      = 32'd0;

  // Fixed-point exponential, Q30.
  localparam logic [30:0] Q30_ONE       = 31'd1073741824;
  localparam logic [28:0] E1_Q30        = 29'd395007542;  // series value at y = 1
  localparam logic [29:0] INV_SQRT2_Q30 = 30'd759250125;
  localparam int unsigned EXP_TERMS     = 12;
  localparam int unsigned EXP_LIMIT     = 24;
  localparam int unsigned POW_STAGES    = EXP_LIMIT - 1;

  // Horner divisor k = ODD << SHIFT.
  localparam int unsigned DIV_SHIFT [1:EXP_TERMS] = '{0, 1, 0, 2, 0, 1, 0, 3, 0, 1, 0, 2};
  localparam int unsigned DIV_ODD   [1:EXP_TERMS] = '{1, 1, 3, 1, 5, 3, 7, 1, 9, 5, 11, 3};
  localparam int unsigned RECIP_SHIFT = 34;

  // squares, sum, beta product, series, powers, diagonal scale, gain
  localparam int unsigned LANE_STAGES = 3 + 2 * EXP_TERMS + POW_STAGES + 2;

endpackage

// ----- design/nlw_ram.sv -----
// Generic simple dual-port RAM: one write port, two registered read ports.
// No dependencies.
module nlw_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on an address collision.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- design/nlw_front.sv -----
// Raster position tracking, previous pixel and line buffer of the previous row.
// Depends on nlw_pkg and nlw_ram.
module nlw_front
  import nlw_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [ROW_WIDTH_W-1:0] row_width,
  input  logic [7:0]             red,
  input  logic [7:0]             green,
  input  logic [7:0]             blue,
  input  logic                   frame_start,
  output pixel_t                 cur,
  output pixel_t                 left_px,
  output pixel_t                 upleft_px,
  output pixel_t                 up_px,
  output pixel_t                 upright_px,
  output border_t                border
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned MAX_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W = (MAX_W > ROW_WIDTH_W) ? MAX_W : ROW_WIDTH_W;

  logic [COL_W-1:0] column;
  logic             first_row;
  pixel_t           prior_pixel;
  pixel_t           prior_up;
  pixel_t           cur_q;
  pixel_t           left_q;
  border_t          border_q;

  pixel_t           pix;
  logic [CMP_W-1:0] rw_ext;
  logic [CMP_W-1:0] width_eff;
  logic [COL_W-1:0] col_eff;
  logic             first_eff;
  logic             last_col;
  logic [COL_W-1:0] upright_addr;
  logic [23:0]      ram_up;
  logic [23:0]      ram_upright;

  always_comb begin
    pix.red   = red;
    pix.green = green;
    pix.blue  = blue;
    rw_ext    = CMP_W'(row_width);
    priority if (rw_ext < CMP_W'(2)) begin
      width_eff = CMP_W'(2);
    end else if (rw_ext > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = rw_ext;
    end
    col_eff      = frame_start ? '0 : column;
    first_eff    = frame_start | first_row;
    // a column at or past the width minus one ends the row
    last_col     = CMP_W'(col_eff) >= (width_eff - CMP_W'(1));
    upright_addr = last_col ? col_eff : col_eff + COL_W'(1);
  end

  nlw_ram #(
    .WIDTH (24),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .we      (accept),
    .waddr   (col_eff),
    .wdata   (pix),
    .re      (accept),
    .raddr_a (col_eff),
    .raddr_b (upright_addr),
    .rdata_a (ram_up),
    .rdata_b (ram_upright)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      first_row   <= 1'b1;
      prior_pixel <= '0;
      prior_up    <= '0;
    end else if (accept) begin
      column      <= last_col ? '0 : col_eff + COL_W'(1);
      first_row   <= last_col ? 1'b0 : first_eff;
      prior_pixel <= pix;
      // the read data still holds the up pixel of the previous transaction
      prior_up    <= ram_up;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_q           <= pix;
      left_q          <= prior_pixel;
      border_q.left    <= (col_eff == '0);
      border_q.upleft  <= first_eff || (col_eff == '0);
      border_q.up      <= first_eff;
      border_q.upright <= first_eff || last_col;
    end
  end

  assign cur        = cur_q;
  assign left_px    = left_q;
  assign upleft_px  = prior_up;
  assign up_px      = ram_up;
  assign upright_px = ram_upright;
  assign border     = border_q;

endmodule

// ----- design/nlw_lane.sv -----
// One weight lane: squared color distance, exp(-beta*d2) series, gain.
// Depends on nlw_pkg.
module nlw_lane
  import nlw_pkg::*;
#(
  parameter bit DIAG = 1'b0
) (
  input  logic                clk,
  input  logic                en,
  input  logic [BETA_W-1:0]   beta,
  input  logic [GAMMA_W-1:0]  gamma,
  input  pixel_t              cur,
  input  pixel_t              nb,
  input  logic                masked,
  output logic [WEIGHT_W-1:0] weight
);

  typedef struct packed {
    logic [23:0] y;
    logic [4:0]  n;
    logic        sat;
    logic        masked;
    logic [30:0] val;
  } lane_ctx_t;

  typedef struct packed {
    logic [4:0]  n;
    logic        sat;
    logic        masked;
    logic [30:0] p;
  } pow_ctx_t;

  logic [7:0]  dr, dg, db;
  logic [15:0] sq_r, sq_g, sq_b;
  logic        masked1, masked2;
  logic [17:0] d2;
  logic [49:0] prod;

  lane_ctx_t ctx [2*EXP_TERMS+1];
  pow_ctx_t  pw  [POW_STAGES+1];
  pow_ctx_t  scl;

  always_comb begin
    dr   = (cur.red > nb.red) ? cur.red - nb.red : nb.red - cur.red;
    dg   = (cur.green > nb.green) ? cur.green - nb.green : nb.green - cur.green;
    db   = (cur.blue > nb.blue) ? cur.blue - nb.blue : nb.blue - cur.blue;
    prod = {18'b0, beta} * {32'b0, d2};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r    <= 16'(dr) * 16'(dr);
      sq_g    <= 16'(dg) * 16'(dg);
      sq_b    <= 16'(db) * 16'(db);
      masked1 <= masked;
      d2      <= 18'(sq_r) + 18'(sq_g) + 18'(sq_b);
      masked2 <= masked1;
      ctx[0].y      <= prod[23:0];
      ctx[0].n      <= prod[28:24];
      ctx[0].sat    <= prod[49:24] >= 26'(EXP_LIMIT);
      ctx[0].masked <= masked2;
      ctx[0].val    <= Q30_ONE;
    end
  end

  // Horner steps, k from EXP_TERMS down to 1: multiply stage, then divide stage.
  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
    localparam int unsigned K   = EXP_TERMS - j;
    localparam int unsigned SH  = DIV_SHIFT[K];
    localparam int unsigned ODD = DIV_ODD[K];
    localparam logic [33:0] RECIP =
      34'(((64'd1 << RECIP_SHIFT) + 64'(ODD) - 64'd1) / 64'(ODD));

    logic [29:0] xs;
    logic [29:0] q;

    assign xs = 30'(ctx[2*j+1].val >> SH);

    if (ODD == 1) begin : g_pow2
      assign q = xs;
    end else begin : g_odd
      assign q = 30'((64'(xs) * 64'(RECIP)) >> RECIP_SHIFT);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx[2*j+1]     <= ctx[2*j];
        ctx[2*j+1].val <= 31'((55'(ctx[2*j].y) * 55'(ctx[2*j].val)) >> 24);
        ctx[2*j+2]     <= ctx[2*j+1];
        ctx[2*j+2].val <= Q30_ONE - 31'(q);
      end
    end
  end

  assign pw[0].n      = ctx[2*EXP_TERMS].n;
  assign pw[0].sat    = ctx[2*EXP_TERMS].sat;
  assign pw[0].masked = ctx[2*EXP_TERMS].masked;
  assign pw[0].p      = ctx[2*EXP_TERMS].val;

  // Integer part: one truncated multiply by exp(-1) per stage while below n.
  for (genvar i = 0; i < POW_STAGES; i++) begin : g_pow
    always_ff @(posedge clk) begin
      if (en) begin
        pw[i+1] <= pw[i];
        if (5'(i) < pw[i].n) begin
          pw[i+1].p <= 31'((62'(pw[i].p) * 62'(E1_Q30)) >> 30);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scl <= pw[POW_STAGES];
      if (DIAG) begin
        scl.p <= 31'((61'(pw[POW_STAGES].p) * 61'(INV_SQRT2_Q30)) >> 30);
      end
      weight <= (scl.sat || scl.masked) ? '0
              : WEIGHT_W'((47'(gamma) * 47'(scl.p)) >> 22);
    end
  end

endmodule

// ----- design/neighbor_link_weights.sv -----
// Neighbor link weight block: 8-neighbor smoothness weights on an RGB stream.
// Depends on nlw_pkg, nlw_front, nlw_lane (and nlw_ram through nlw_front).
//
// Usage:
//   Pixels arrive in raster order on red/green/blue with pixel_valid; a
//   transaction completes on a clock edge with pixel_valid high and
//   pixel_stall low. frame_start marks the first pixel of a frame.
//   Each pixel yields one transaction on the weight channel carrying the
//   left, up-left, up and up-right weights (Q8.16), taken when weight_valid
//   is high and weight_stall low.
//   Configuration (row_width, gamma, beta) is written through cfg_valid /
//   cfg_ready with cfg_index and cfg_data while the pipeline is empty;
//   cfg_ready is always high.
//   Throughput: one pixel per clock while no stall is held. The pipeline
//   depth is set mostly by the 12-step exponential series (two stages
//   per step) and the 23 stages of exp(-1) powers.
//   Stall: while a result is held with weight_stall high the whole pipeline
//   holds and pixel_stall is raised; nothing is dropped or repeated.
//   Reset: clears valid bits, raster position and configuration registers
//   to their reset values; line buffer contents are not cleared.
module neighbor_link_weights
  import nlw_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic                  frame_start,
  output logic                  weight_valid,
  input  logic                  weight_stall,
  output logic [WEIGHT_W-1:0]   left_weight,
  output logic [WEIGHT_W-1:0]   upleft_weight,
  output logic [WEIGHT_W-1:0]   up_weight,
  output logic [WEIGHT_W-1:0]   upright_weight,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned PIPE_DEPTH = 1 + LANE_STAGES;

  logic [ROW_WIDTH_W-1:0] row_width;
  logic [GAMMA_W-1:0]     gamma;
  logic [BETA_W-1:0]      beta;

  logic                  advance;
  logic                  accept;
  logic [PIPE_DEPTH-1:0] valid;

  pixel_t  cur, left_px, upleft_px, up_px, upright_px;
  border_t border;

  assign cfg_ready    = 1'b1;
  assign advance      = !(weight_valid && weight_stall);
  assign accept       = pixel_valid && advance;
  assign pixel_stall  = !advance;
  assign weight_valid = valid[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
      gamma     <= GAMMA_RESET;
      beta      <= BETA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROW_WIDTH: row_width <= cfg_data[ROW_WIDTH_W-1:0];
        CFG_GAMMA:     gamma     <= cfg_data[GAMMA_W-1:0];
        CFG_BETA:      beta      <= cfg_data[BETA_W-1:0];
        default:       ;
      endcase
    end
  end

  // Valid bits advance with the payload; hold everything on a stalled output.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (advance) begin
      valid <= {valid[PIPE_DEPTH-2:0], accept};
    end
  end

  nlw_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .row_width   (row_width),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .frame_start (frame_start),
    .cur         (cur),
    .left_px     (left_px),
    .upleft_px   (upleft_px),
    .up_px       (up_px),
    .upright_px  (upright_px),
    .border      (border)
  );

  nlw_lane #(.DIAG(1'b0)) u_left (
    .clk    (clk),
    .en     (advance),
    .beta   (beta),
    .gamma  (gamma),
    .cur    (cur),
    .nb     (left_px),
    .masked (border.left),
    .weight (left_weight)
  );

  nlw_lane #(.DIAG(1'b1)) u_upleft (
    .clk    (clk),
    .en     (advance),
    .beta   (beta),
    .gamma  (gamma),
    .cur    (cur),
    .nb     (upleft_px),
    .masked (border.upleft),
    .weight (upleft_weight)
  );

  nlw_lane #(.DIAG(1'b0)) u_up (
    .clk    (clk),
    .en     (advance),
    .beta   (beta),
    .gamma  (gamma),
    .cur    (cur),
    .nb     (up_px),
    .masked (border.up),
    .weight (up_weight)
  );

  nlw_lane #(.DIAG(1'b1)) u_upright (
    .clk    (clk),
    .en     (advance),
    .beta   (beta),
    .gamma  (gamma),
    .cur    (cur),
    .nb     (upright_px),
    .masked (border.upright),
    .weight (upright_weight)
  );

endmodule

// ----- design/nlw_checker.sv -----
// Port-level checks of the neighbor link weight block, bound to the top level.
// Depends on neighbor_link_weights_assert.svh and the top level's ports.
`include "neighbor_link_weights_assert.svh"

module nlw_checker (
  input logic        clk,
  input logic        rst,
  input logic        pixel_valid,
  input logic        pixel_stall,
  input logic        weight_valid,
  input logic        weight_stall,
  input logic [23:0] left_weight,
  input logic [23:0] upleft_weight,
  input logic [23:0] up_weight,
  input logic [23:0] upright_weight
);

  // no result may come out of reset
  `NLW_ASSERT_ALWAYS(a_reset_empty, rst |=> !weight_valid, "weight_valid set after reset")

  // input backpressure only comes from a held result
  `NLW_ASSERT(a_stall_cause, pixel_stall |-> weight_valid && weight_stall, "stall without held result")

  `NLW_ASSERT(a_out_hold, weight_valid && weight_stall |=> weight_valid && $stable(left_weight) && $stable(upleft_weight) && $stable(up_weight) && $stable(upright_weight), "held result changed")

endmodule

bind neighbor_link_weights nlw_checker u_nlw_checker (.*);
